// ----- rtl/max_priority_queue_keyed_core_defines.svh -----
// Assertion macros for the priority queue RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef MAX_PRIORITY_QUEUE_KEYED_CORE_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_KEYED_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PMQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PMQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pmq_pkg.sv -----
// Shared types, command codes and the ranking function of the priority queue.
// No dependencies; used by pmq_cell_array and max_priority_queue_keyed_core.
`timescale 1ns / 1ps

package pmq_pkg;

  localparam int PMQ_DEPTH_DEF = 64;

  localparam int KIND_W  = 2;
  localparam int SCORE_W = 10;
  localparam int ID_W    = 16;
  localparam int TAG_W   = 32;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd3;

  typedef struct packed {
    logic               go;
    logic [KIND_W-1:0]  kind;
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
    logic [TAG_W-1:0]   tag;
  } pmq_cmd_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
    logic [TAG_W-1:0]   tag;
  } pmq_top_t;

  // True when record (s, i) ranks ahead of the record held in a cell.
  function automatic logic ranks_before(input logic [SCORE_W-1:0] s,
                                        input logic [ID_W-1:0]    i,
                                        input logic [SCORE_W-1:0] cs,
                                        input logic [ID_W-1:0]    ci);
    logic r;
    if (s != cs) begin
      r = (s > cs);
    end else begin
      r = (i < ci);
    end
    return r;
  endfunction

endpackage

// ----- rtl/pmq_cell_array.sv -----
// Sorted shifting cell array with occupancy counter; cell 0 always holds the top.
// Depends on pmq_pkg and max_priority_queue_keyed_core_defines.svh.
`timescale 1ns / 1ps
`include "max_priority_queue_keyed_core_defines.svh"

module pmq_cell_array
  import pmq_pkg::*;
#(
  parameter int DEPTH = PMQ_DEPTH_DEF,
  localparam int OCC_W = $clog2(DEPTH + 1)
) (
  input  logic     clk,
  input  logic     rst_n,
  input  pmq_cmd_t cmd_i,
  output pmq_top_t top_o
);

  logic [SCORE_W-1:0] score_r   [DEPTH];
  logic [SCORE_W-1:0] score_nxt [DEPTH];
  logic [ID_W-1:0]    id_r      [DEPTH];
  logic [ID_W-1:0]    id_nxt    [DEPTH];
  logic [TAG_W-1:0]   tag_r     [DEPTH];
  logic [TAG_W-1:0]   tag_nxt   [DEPTH];
  logic [OCC_W-1:0]   occ_r;
  logic [OCC_W-1:0]   occ_nxt;

  logic             full;
  logic             ins_en;
  logic             pop_en;
  logic [DEPTH-1:0] ahead;
  logic [DEPTH-1:0] ahead_up;

  always_comb begin
    full   = (occ_r == OCC_W'(DEPTH));
    ins_en = cmd_i.go && (cmd_i.kind == KIND_INSERT || cmd_i.kind == KIND_LOAD) && !full;
    pop_en = cmd_i.go && (cmd_i.kind == KIND_POP) && (occ_r != '0);
  end

  // The cells are sorted, so the set of cells the new record ranks ahead of
  // (empty cells included) is a suffix; the new record lands at its first cell.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      ahead[k] = (OCC_W'(k) >= occ_r) ||
                 ranks_before(cmd_i.score, cmd_i.id, score_r[k], id_r[k]);
    end
    ahead_up = {ahead[DEPTH-2:0], 1'b0};
  end

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      int dn;
      int up;
      dn = (k == 0) ? 0 : k - 1;
      up = (k == DEPTH - 1) ? k : k + 1;
      score_nxt[k] = score_r[k];
      id_nxt[k]    = id_r[k];
      tag_nxt[k]   = tag_r[k];
      if (ins_en && ahead[k]) begin
        if (!ahead_up[k]) begin
          score_nxt[k] = cmd_i.score;
          id_nxt[k]    = cmd_i.id;
          tag_nxt[k]   = cmd_i.tag;
        end else begin
          score_nxt[k] = score_r[dn];
          id_nxt[k]    = id_r[dn];
          tag_nxt[k]   = tag_r[dn];
        end
      end else if (pop_en) begin
        score_nxt[k] = score_r[up];
        id_nxt[k]    = id_r[up];
        tag_nxt[k]   = tag_r[up];
      end
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (ins_en) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (pop_en) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_comb begin
    top_o.empty = (occ_nxt == '0);
    top_o.full  = full;
    top_o.score = top_o.empty ? '0 : score_nxt[0];
    top_o.id    = top_o.empty ? '0 : id_nxt[0];
    top_o.tag   = top_o.empty ? '0 : tag_nxt[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    id_r    <= id_nxt;
    tag_r   <= tag_nxt;
  end

  `PMQ_ASSERT_IMP(a_occ_bound, 1'b1, occ_r <= OCC_W'(DEPTH), "occupancy above depth")
  `PMQ_ASSERT_NXT(a_pop_dec, cmd_i.go && cmd_i.kind == KIND_POP && occ_r != '0,
                  occ_r == $past(occ_r) - OCC_W'(1), "pop did not shrink queue")
  `PMQ_ASSERT_NXT(a_ins_inc,
                  cmd_i.go && (cmd_i.kind == KIND_INSERT || cmd_i.kind == KIND_LOAD) && !full,
                  occ_r == $past(occ_r) + OCC_W'(1), "insert did not grow queue")
  `PMQ_ASSERT_NXT(a_hold, !cmd_i.go || cmd_i.kind == KIND_PEEK ||
                  ((cmd_i.kind == KIND_INSERT || cmd_i.kind == KIND_LOAD) && full),
                  $stable(occ_r), "occupancy changed without a change command")

endmodule

// ----- rtl/max_priority_queue_keyed_core.sv -----
// Bounded max-priority queue of keyed records: input register, cell array, result register.
// Depends on pmq_pkg and pmq_cell_array.
`timescale 1ns / 1ps

// One command item is taken per clock cycle unless a held result stalls a reporting
// item; its result, if any, passes from the input register through the cell array
// into the result register. Every cell compares the incoming record with its own
// keys and shifts by one, so an insert, pop or peek finishes in one pass. A held
// result on the output stalls only items that report; silent inserts keep flowing.
// DEPTH sets the capacity; an insert into a full queue is dropped and flagged in the
// result of a reporting insert.
module max_priority_queue_keyed_core
  import pmq_pkg::*;
#(
  parameter int DEPTH = PMQ_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // score[9:0], record_id[25:10], payload_tag[57:26]
  input  logic [KIND_W-1:0]      in_tuser,   // kind[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // top_score[9:0], top_id[25:10], top_tag[57:26]
  output logic [OUT_TUSER_W-1:0] out_tuser   // is_empty[0], dropped_full[1]
);

  logic               stg_v_r;
  logic [KIND_W-1:0]  stg_kind_r;
  logic [SCORE_W-1:0] stg_score_r;
  logic [ID_W-1:0]    stg_id_r;
  logic [TAG_W-1:0]   stg_tag_r;

  logic               out_v_r;
  logic               out_empty_r;
  logic               out_drop_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [ID_W-1:0]    out_id_r;
  logic [TAG_W-1:0]   out_tag_r;

  logic     stg_go;
  logic     stg_reports;
  pmq_cmd_t cmd;
  pmq_top_t top;

  always_comb begin
    stg_reports = (stg_kind_r != KIND_LOAD);
    stg_go      = stg_v_r && (!stg_reports || !out_v_r || out_tready);
    in_tready   = !stg_v_r || stg_go;
    cmd.go      = stg_go;
    cmd.kind    = stg_kind_r;
    cmd.score   = stg_score_r;
    cmd.id      = stg_id_r;
    cmd.tag     = stg_tag_r;
  end

  pmq_cell_array #(
    .DEPTH(DEPTH)
  ) u_cells (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_i (cmd),
    .top_o (top)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_tready) begin
      stg_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_kind_r  <= in_tuser;
      stg_score_r <= in_tdata[SCORE_W-1:0];
      stg_id_r    <= in_tdata[SCORE_W+ID_W-1:SCORE_W];
      stg_tag_r   <= in_tdata[SCORE_W+ID_W+TAG_W-1:SCORE_W+ID_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (stg_go && stg_reports) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_go && stg_reports) begin
      out_empty_r <= top.empty;
      out_drop_r  <= (stg_kind_r == KIND_INSERT) && top.full;
      out_score_r <= top.score;
      out_id_r    <= top.id;
      out_tag_r   <= top.tag;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = {out_drop_r, out_empty_r};
  assign out_tdata  = {{(OUT_TDATA_W - SCORE_W - ID_W - TAG_W){1'b0}},
                       out_tag_r, out_id_r, out_score_r};

endmodule
